FILE: rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types and constants of the attitude observation builder.
// ----------------------------------------------------------------------------
package aob_pkg;

  // Default number of fractional bits of the fixed-point values.
  localparam int FRAC_BITS_DEF = 16;

  // Item kinds carried on req_type.
  localparam logic [1:0] REQ_QUAT = 2'd0;
  localparam logic [1:0] REQ_POS  = 2'd1;
  localparam logic [1:0] REQ_VEL  = 2'd2;
  localparam logic [1:0] REQ_EMIT = 2'd3;

  // Configuration register indexes and their reset values.
  localparam int         CFG_IDX_W     = 2;
  localparam int         LIMIT_W       = 31;
  localparam logic [1:0] CFG_POS_LIMIT = 2'd0;
  localparam logic [1:0] CFG_VEL_LIMIT = 2'd1;
  localparam logic [LIMIT_W-1:0] POS_LIMIT_RST = 31'd39322;
  localparam logic [LIMIT_W-1:0] VEL_LIMIT_RST = 31'd131072;

  // Observation vector.
  localparam int         OBS_IDX_W    = 5;
  localparam logic [4:0] OBS_LAST_IDX = 5'd17;

  // pi/180 with 32 fractional bits.
  localparam logic signed [31:0] DEG2RAD_Q32 = 32'sd74961321;

  // Multiplier operations: quaternion products, then body-velocity terms
  // (column j, component i: r[3i+j] * v_i), then gyro conversions.
  localparam logic [4:0] OP_QXX = 5'd0;
  localparam logic [4:0] OP_QYY = 5'd1;
  localparam logic [4:0] OP_QZZ = 5'd2;
  localparam logic [4:0] OP_QXY = 5'd3;
  localparam logic [4:0] OP_QXZ = 5'd4;
  localparam logic [4:0] OP_QYZ = 5'd5;
  localparam logic [4:0] OP_QWX = 5'd6;
  localparam logic [4:0] OP_QWY = 5'd7;
  localparam logic [4:0] OP_QWZ = 5'd8;
  localparam logic [4:0] OP_B0X = 5'd9;
  localparam logic [4:0] OP_B0Y = 5'd10;
  localparam logic [4:0] OP_B0Z = 5'd11;
  localparam logic [4:0] OP_B1X = 5'd12;
  localparam logic [4:0] OP_B1Y = 5'd13;
  localparam logic [4:0] OP_B1Z = 5'd14;
  localparam logic [4:0] OP_B2X = 5'd15;
  localparam logic [4:0] OP_B2Y = 5'd16;
  localparam logic [4:0] OP_B2Z = 5'd17;
  localparam logic [4:0] OP_GX  = 5'd18;
  localparam logic [4:0] OP_GY  = 5'd19;
  localparam logic [4:0] OP_GZ  = 5'd20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load_en;   // a load item is accepted this cycle
    logic                 gyro_ld;   // an emit item is accepted this cycle
    logic                 mul_en;    // issue one multiplier operation
    logic [4:0]           op;
    logic                 mat_en;    // build the rotation matrix
    logic                 emit_en;   // present one observation beat
    logic [OBS_IDX_W-1:0] emit_idx;
  } cmd_t;

endpackage

FILE: rtl/aob_ctrl.sv
// ----------------------------------------------------------------------------
// aob_ctrl
// Sequencer: accepts items and steps the shared multiplier and the output.
// ----------------------------------------------------------------------------
module aob_ctrl
  import aob_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] req_type_i,
  output logic       busy_o,
  output cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_QMUL   = 7'b0000010,
    S_QDRAIN = 7'b0000100,
    S_MAT    = 7'b0001000,
    S_VMUL   = 7'b0010000,
    S_VDRAIN = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    cmd_o            = '0;
    cmd_o.load_en    = accept && (req_type_i != REQ_EMIT);
    cmd_o.gyro_ld    = accept && (req_type_i == REQ_EMIT);
    cmd_o.op         = step_q;
    cmd_o.emit_idx   = step_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == REQ_EMIT)) begin
          state_d = S_QMUL;
          step_d  = OP_QXX;
        end
      end
      S_QMUL: begin
        cmd_o.mul_en = 1'b1;
        step_d       = step_q + 5'd1;
        if (step_q == OP_QWZ) begin
          state_d = S_QDRAIN;
        end
      end
      S_QDRAIN: begin
        state_d = S_MAT;
      end
      S_MAT: begin
        cmd_o.mat_en = 1'b1;
        state_d      = S_VMUL;
        step_d       = OP_B0X;
      end
      S_VMUL: begin
        cmd_o.mul_en = 1'b1;
        step_d       = step_q + 5'd1;
        if (step_q == OP_GZ) begin
          state_d = S_VDRAIN;
        end
      end
      S_VDRAIN: begin
        state_d = S_EMIT;
        step_d  = '0;
      end
      S_EMIT: begin
        cmd_o.emit_en = 1'b1;
        step_d        = step_q + 5'd1;
        if (step_q == OBS_LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // The multiplier and the output are never driven in the same cycle.
  a_mul_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mul_en && cmd_o.emit_en))
    else $error("multiplier and output beat issued together");

  // An accepted emit item starts the product sequence.
  a_emit_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_EMIT)) |=> (state_q == S_QMUL && step_q == OP_QXX))
    else $error("emit item did not start the sequence");

  // The final beat returns the sequencer to idle.
  a_last_beat_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_en && cmd_o.emit_idx == OBS_LAST_IDX) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after the last beat");

endmodule

FILE: rtl/aob_dpath.sv
// ----------------------------------------------------------------------------
// aob_dpath
// Stores, clip logic, shared multiplier, matrix build and output register.
// ----------------------------------------------------------------------------
module aob_dpath
  import aob_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [1:0]           req_type_i,
  input  logic signed [31:0]   quat_w_i,
  input  logic signed [31:0]   meas_x_i,
  input  logic signed [31:0]   meas_y_i,
  input  logic signed [31:0]   meas_z_i,
  input  logic signed [31:0]   ref_x_i,
  input  logic signed [31:0]   ref_y_i,
  input  logic signed [31:0]   ref_z_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  output logic                 obs_valid_o,
  output logic [OBS_IDX_W-1:0] obs_index_o,
  output logic signed [31:0]   obs_value_o,
  output logic                 obs_last_o
);

  localparam logic signed [66:0] ONE = 67'sd1 <<< FRAC_BITS;

  // Measured minus target in 33 bits, clipped to [-lim, lim].
  function automatic logic signed [31:0] clip_diff(logic signed [31:0] m,
                                                   logic signed [31:0] r,
                                                   logic [LIMIT_W-1:0] lim);
    logic signed [32:0] d;
    logic signed [32:0] l;
    logic signed [32:0] res;
    d   = {m[31], m} - {r[31], r};
    l   = {2'b00, lim};
    res = d;
    if (d > l) begin
      res = l;
    end else if (d < -l) begin
      res = -l;
    end
    return res[31:0];
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(logic signed [66:0] x);
    logic signed [31:0] res;
    if (x > 67'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -67'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  logic [LIMIT_W-1:0] pos_lim_q, vel_lim_q;
  logic signed [31:0] quat_q [4];
  logic signed [31:0] pos_q  [3];
  logic signed [31:0] vel_q  [3];
  logic signed [31:0] gyro_q [3];
  logic signed [64:0] pq_q   [9];
  logic signed [31:0] rm_q   [9];
  logic signed [65:0] acc_q  [3];
  logic signed [31:0] rad_q  [3];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d, prod_q;
  logic signed [63:0] term;
  logic [4:0]         tag_q;
  logic               tag_vld_q;
  logic [1:0]         tag_col;
  logic               tag_first;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lim_q <= POS_LIMIT_RST;
      vel_lim_q <= VEL_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_POS_LIMIT) begin
        pos_lim_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_VEL_LIMIT) begin
        vel_lim_q <= cfg_wdata_i;
      end
    end
  end

  // Stored quaternion and clipped errors, loaded by load items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q <= '{default: '0};
      pos_q  <= '{default: '0};
      vel_q  <= '{default: '0};
    end else if (cmd_i.load_en) begin
      case (req_type_i)
        REQ_QUAT: begin
          quat_q[0] <= quat_w_i;
          quat_q[1] <= meas_x_i;
          quat_q[2] <= meas_y_i;
          quat_q[3] <= meas_z_i;
        end
        REQ_POS: begin
          pos_q[0] <= clip_diff(meas_x_i, ref_x_i, pos_lim_q);
          pos_q[1] <= clip_diff(meas_y_i, ref_y_i, pos_lim_q);
          pos_q[2] <= clip_diff(meas_z_i, ref_z_i, pos_lim_q);
        end
        REQ_VEL: begin
          vel_q[0] <= clip_diff(meas_x_i, ref_x_i, vel_lim_q);
          vel_q[1] <= clip_diff(meas_y_i, ref_y_i, vel_lim_q);
          vel_q[2] <= clip_diff(meas_z_i, ref_z_i, vel_lim_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Gyro rates of the emit item, held for the conversion.
  always_ff @(posedge clk_i) begin
    if (cmd_i.gyro_ld) begin
      gyro_q[0] <= meas_x_i;
      gyro_q[1] <= meas_y_i;
      gyro_q[2] <= meas_z_i;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = quat_q[1];
    mul_b = quat_q[1];
    case (cmd_i.op)
      OP_QXX: begin mul_a = quat_q[1]; mul_b = quat_q[1]; end
      OP_QYY: begin mul_a = quat_q[2]; mul_b = quat_q[2]; end
      OP_QZZ: begin mul_a = quat_q[3]; mul_b = quat_q[3]; end
      OP_QXY: begin mul_a = quat_q[1]; mul_b = quat_q[2]; end
      OP_QXZ: begin mul_a = quat_q[1]; mul_b = quat_q[3]; end
      OP_QYZ: begin mul_a = quat_q[2]; mul_b = quat_q[3]; end
      OP_QWX: begin mul_a = quat_q[0]; mul_b = quat_q[1]; end
      OP_QWY: begin mul_a = quat_q[0]; mul_b = quat_q[2]; end
      OP_QWZ: begin mul_a = quat_q[0]; mul_b = quat_q[3]; end
      OP_B0X: begin mul_a = rm_q[0];   mul_b = vel_q[0];  end
      OP_B0Y: begin mul_a = rm_q[3];   mul_b = vel_q[1];  end
      OP_B0Z: begin mul_a = rm_q[6];   mul_b = vel_q[2];  end
      OP_B1X: begin mul_a = rm_q[1];   mul_b = vel_q[0];  end
      OP_B1Y: begin mul_a = rm_q[4];   mul_b = vel_q[1];  end
      OP_B1Z: begin mul_a = rm_q[7];   mul_b = vel_q[2];  end
      OP_B2X: begin mul_a = rm_q[2];   mul_b = vel_q[0];  end
      OP_B2Y: begin mul_a = rm_q[5];   mul_b = vel_q[1];  end
      OP_B2Z: begin mul_a = rm_q[8];   mul_b = vel_q[2];  end
      OP_GX:  begin mul_a = gyro_q[0]; mul_b = DEG2RAD_Q32; end
      OP_GY:  begin mul_a = gyro_q[1]; mul_b = DEG2RAD_Q32; end
      OP_GZ:  begin mul_a = gyro_q[2]; mul_b = DEG2RAD_Q32; end
      default: begin
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Product register and the operation it belongs to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
      tag_q     <= '0;
    end else begin
      tag_vld_q <= cmd_i.mul_en;
      tag_q     <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Truncated product, rounding toward minus infinity.
  assign term = prod_q >>> FRAC_BITS;

  // Which body-velocity column a term belongs to, and whether it opens it.
  always_comb begin
    tag_col   = 2'd0;
    tag_first = 1'b0;
    case (tag_q)
      OP_B0X:  begin tag_col = 2'd0; tag_first = 1'b1; end
      OP_B0Y:  tag_col = 2'd0;
      OP_B0Z:  tag_col = 2'd0;
      OP_B1X:  begin tag_col = 2'd1; tag_first = 1'b1; end
      OP_B1Y:  tag_col = 2'd1;
      OP_B1Z:  tag_col = 2'd1;
      OP_B2X:  begin tag_col = 2'd2; tag_first = 1'b1; end
      OP_B2Y:  tag_col = 2'd2;
      OP_B2Z:  tag_col = 2'd2;
      default: begin
      end
    endcase
  end

  // Write-back of the product to its destination.
  always_ff @(posedge clk_i) begin
    if (tag_vld_q) begin
      if (tag_q <= OP_QWZ) begin
        pq_q[tag_q[3:0]] <= {term, 1'b0};
      end else if (tag_q < OP_GX) begin
        if (tag_first) begin
          acc_q[tag_col] <= {{2{term[63]}}, term};
        end else begin
          acc_q[tag_col] <= acc_q[tag_col] + {{2{term[63]}}, term};
        end
      end else if (tag_q == OP_GX) begin
        rad_q[0] <= prod_q[63:32];
      end else if (tag_q == OP_GY) begin
        rad_q[1] <= prod_q[63:32];
      end else begin
        rad_q[2] <= prod_q[63:32];
      end
    end
  end

  // Rotation matrix from the doubled products, saturated entry by entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_en) begin
      rm_q[0] <= sat32(ONE - 67'(pq_q[OP_QYY[3:0]]) - 67'(pq_q[OP_QZZ[3:0]]));
      rm_q[1] <= sat32(67'(pq_q[OP_QXY[3:0]]) - 67'(pq_q[OP_QWZ[3:0]]));
      rm_q[2] <= sat32(67'(pq_q[OP_QXZ[3:0]]) + 67'(pq_q[OP_QWY[3:0]]));
      rm_q[3] <= sat32(67'(pq_q[OP_QXY[3:0]]) + 67'(pq_q[OP_QWZ[3:0]]));
      rm_q[4] <= sat32(ONE - 67'(pq_q[OP_QXX[3:0]]) - 67'(pq_q[OP_QZZ[3:0]]));
      rm_q[5] <= sat32(67'(pq_q[OP_QYZ[3:0]]) - 67'(pq_q[OP_QWX[3:0]]));
      rm_q[6] <= sat32(67'(pq_q[OP_QXZ[3:0]]) - 67'(pq_q[OP_QWY[3:0]]));
      rm_q[7] <= sat32(67'(pq_q[OP_QYZ[3:0]]) + 67'(pq_q[OP_QWX[3:0]]));
      rm_q[8] <= sat32(ONE - 67'(pq_q[OP_QXX[3:0]]) - 67'(pq_q[OP_QYY[3:0]]));
    end
  end

  // Observation selection for the current beat.
  logic signed [31:0]   obs_sel;
  logic [OBS_IDX_W-1:0] sub_idx;
  always_comb begin
    sub_idx = '0;
    if (cmd_i.emit_idx < 5'd3) begin
      obs_sel = pos_q[cmd_i.emit_idx[1:0]];
    end else if (cmd_i.emit_idx < 5'd12) begin
      sub_idx = cmd_i.emit_idx - 5'd3;
      obs_sel = rm_q[sub_idx[3:0]];
    end else if (cmd_i.emit_idx < 5'd15) begin
      sub_idx = cmd_i.emit_idx - 5'd12;
      obs_sel = sat32({acc_q[sub_idx[1:0]][65], acc_q[sub_idx[1:0]]});
    end else begin
      sub_idx = cmd_i.emit_idx - 5'd15;
      obs_sel = rad_q[sub_idx[1:0]];
    end
  end

  // Output register: one beat per cycle while emitting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_valid_o <= 1'b0;
      obs_last_o  <= 1'b0;
    end else begin
      obs_valid_o <= cmd_i.emit_en;
      obs_last_o  <= cmd_i.emit_en && (cmd_i.emit_idx == OBS_LAST_IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      obs_index_o <= cmd_i.emit_idx;
      obs_value_o <= obs_sel;
    end
  end

  // The last flag only marks the final beat of a vector.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obs_last_o |-> (obs_valid_o && obs_index_o == OBS_LAST_IDX))
    else $error("last flag on a beat other than the final one");

endmodule

FILE: rtl/attitude_observation_builder_core.sv
// ----------------------------------------------------------------------------
// attitude_observation_builder_core
// Builds the 18-element observation vector from a stored quaternion, clipped
// position and velocity errors and gyro rates, in signed fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Signals
//  --------  ---------------------  ----------------------------------------
//  item in   start_i && !busy_o     req_type_i, quat_w_i, meas_*_i, ref_*_i
//  result    obs_valid_o (strobe)   obs_index_o, obs_value_o, obs_last_o
//  config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A load item (quaternion, position, velocity) is taken when accepted and
// busy_o stays low. An emit item keeps busy_o high through 21 passes through
// the one shared 32x32 multiplier, the drain and matrix states, then 18
// output beats, one per cycle, each registered the cycle after its issue.
// The receiver cannot stall, so the beat sequence is never interrupted.
// Reset restores the limits to their reset values and clears the load stores.
// ----------------------------------------------------------------------------
module attitude_observation_builder_core
  import aob_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           req_type_i,
  input  logic signed [31:0]   quat_w_i,
  input  logic signed [31:0]   meas_x_i,
  input  logic signed [31:0]   meas_y_i,
  input  logic signed [31:0]   meas_z_i,
  input  logic signed [31:0]   ref_x_i,
  input  logic signed [31:0]   ref_y_i,
  input  logic signed [31:0]   ref_z_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  output logic                 obs_valid_o,
  output logic [OBS_IDX_W-1:0] obs_index_o,
  output logic signed [31:0]   obs_value_o,
  output logic                 obs_last_o
);

  cmd_t cmd;

  // Sequencer.
  aob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .busy_o     (busy_o),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  aob_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (req_type_i),
    .quat_w_i    (quat_w_i),
    .meas_x_i    (meas_x_i),
    .meas_y_i    (meas_y_i),
    .meas_z_i    (meas_z_i),
    .ref_x_i     (ref_x_i),
    .ref_y_i     (ref_y_i),
    .ref_z_i     (ref_z_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .obs_valid_o (obs_valid_o),
    .obs_index_o (obs_index_o),
    .obs_value_o (obs_value_o),
    .obs_last_o  (obs_last_o)
  );

endmodule
